// File: sv/sva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound voice allocator package
// Shared sizes, codes and structs for the channel cell chain.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int HIGH_CHANNELS  = 4;
  localparam int LOW_CHANNELS   = 12;
  localparam int TAG_BITS       = 8;
  localparam int TOTAL_CHANNELS = HIGH_CHANNELS + LOW_CHANNELS;
  localparam int IDX_W          = (TOTAL_CHANNELS > 2) ? $clog2(TOTAL_CHANNELS) : 1;
  localparam int FIN_W          = (IDX_W > 4) ? IDX_W : 4;

  localparam logic [1:0] CMD_PLAY   = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_STOPPED = 2'd1;
  localparam logic [1:0] ACT_STARTED = 2'd2;
  localparam logic [1:0] ACT_STOLEN  = 2'd3;

  localparam logic [6:0] VOL_MAX = 7'd100;

  typedef struct packed {
    logic [1:0]          command;
    logic [TAG_BITS-1:0] tag;
    logic                known;
    logic                high_priority;
    logic [6:0]          volume;
    logic                looping;
    logic [3:0]          fin;
  } sva_cmd_t;

  typedef struct packed {
    logic                play_en;
    logic                stop_en;
    logic                fin_en;
    logic                all_busy;
    logic [IDX_W-1:0]    steal_idx;
    logic [TAG_BITS-1:0] tag;
    logic [FIN_W-1:0]    fin;
  } sva_bcast_t;

  typedef struct packed {
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             tag_found;
    logic [IDX_W-1:0] tag_idx;
    logic             tag_playing;
  } sva_link_t;

endpackage

// File: sv/sva_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound voice allocator request channel
// Valid/ready channel carrying one allocation command per transfer.
// ----------------------------------------------------------------------------
interface sva_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] sound_tag;
  logic       sound_known;
  logic       high_priority;
  logic [6:0] volume;
  logic       looping;
  logic [3:0] finished_channel;

  modport source (
    output valid, command, sound_tag, sound_known, high_priority, volume, looping,
           finished_channel,
    input  ready
  );
  modport sink (
    input  valid, command, sound_tag, sound_known, high_priority, volume, looping,
           finished_channel,
    output ready
  );
endinterface

// File: sv/sva_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound voice allocator response channel
// Valid/ready channel carrying one allocation result per transfer.
// ----------------------------------------------------------------------------
interface sva_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] channel;
  logic [7:0] out_tag;
  logic [6:0] out_volume;
  logic       out_looping;

  modport source (
    output valid, action, channel, out_tag, out_volume, out_looping,
    input  ready
  );
  modport sink (
    input  valid, action, channel, out_tag, out_volume, out_looping,
    output ready
  );
endinterface

// File: sv/sva_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound voice allocator channel cell
// Holds one channel's tag, assigned and playing bits; extends the priority
// chain for the free-channel and tag searches and applies the broadcast update.
// ----------------------------------------------------------------------------
module sva_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sva_pkg::IDX_W-1:0]      idx_i,
  input  sva_pkg::sva_bcast_t            bcast_i,
  input  sva_pkg::sva_link_t             link_i,
  output sva_pkg::sva_link_t             link_o
);
  import sva_pkg::*;

  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                assigned_q, assigned_d;
  logic                playing_q, playing_d;
  logic                free_here, tag_here, take, stop, fin;

  assign free_here = !playing_q;
  assign tag_here  = assigned_q && (tag_q == bcast_i.tag);

  always_comb begin
    link_o.free_found  = link_i.free_found | free_here;
    link_o.free_idx    = link_i.free_found ? link_i.free_idx : idx_i;
    link_o.tag_found   = link_i.tag_found | tag_here;
    link_o.tag_idx     = link_i.tag_found ? link_i.tag_idx : idx_i;
    link_o.tag_playing = link_i.tag_found ? link_i.tag_playing : playing_q;
  end

  assign take = bcast_i.play_en &&
                (bcast_i.all_busy ? (bcast_i.steal_idx == idx_i)
                                  : (free_here && !link_i.free_found));
  assign stop = bcast_i.stop_en && tag_here && !link_i.tag_found && playing_q;
  assign fin  = bcast_i.fin_en && (bcast_i.fin == FIN_W'(idx_i));

  always_comb begin
    tag_d      = take ? bcast_i.tag : tag_q;
    assigned_d = assigned_q | take;
    if (take) begin
      playing_d = 1'b1;
    end else if (stop || fin) begin
      playing_d = 1'b0;
    end else begin
      playing_d = playing_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assigned_q <= 1'b0;
      playing_q  <= 1'b0;
    end else begin
      assigned_q <= assigned_d;
      playing_q  <= playing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

endmodule

// File: sv/sound_voice_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound voice allocator
// Assigns playback channels to play, stop and finished commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command per transfer: play (with tag, known flag,
//   priority, volume and loop), stop by tag, or channel finished.
//   rsp_o returns exactly one result per command: action, channel, tag,
//   volume and loop setting; unused fields read zero.
//   Timing: a command is registered at its transfer and resolved once
//   the output register is free, when its result is loaded into it.
//   Flow: a new command is taken only while the command register is
//   empty; each command makes one pass through the chain of channel cells,
//   which carries the lowest-free and lowest-tag searches from cell to cell.
//   Stall: while the result waits for rsp_o.ready, one more command is taken
//   and held; it is resolved once the output register is free.
//   Reset: all channels stopped and unassigned, high pointer at channel 0,
//   low pointer at the first low-priority channel, both channels empty.
// ----------------------------------------------------------------------------
module sound_voice_allocator_top (
  input  logic clk_i,
  input  logic rst_ni,
  sva_req_if.sink   req_i,
  sva_rsp_if.source rsp_o
);
  import sva_pkg::*;

  sva_cmd_t         cmd_q;
  logic             cmd_valid_q, cmd_valid_d;
  logic [IDX_W-1:0] high_ptr_q, high_ptr_d;
  logic [IDX_W-1:0] low_ptr_q, low_ptr_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic [1:0]       act_q, act_d;
  logic [3:0]       ch_q, ch_d;
  logic [7:0]       tag_q, tag_d;
  logic [6:0]       vol_q, vol_d;
  logic             loop_q, loop_d;

  logic             req_fire, exec;
  logic             play_ok, stolen;
  logic [6:0]       vol_sat;
  sva_bcast_t       bcast;
  sva_link_t        link [TOTAL_CHANNELS+1];

  assign req_i.ready = !cmd_valid_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign exec        = cmd_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign vol_sat     = (req_i.volume > VOL_MAX) ? VOL_MAX : req_i.volume;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q.command       <= req_i.command;
      cmd_q.tag           <= TAG_BITS'(req_i.sound_tag);
      cmd_q.known         <= req_i.sound_known;
      cmd_q.high_priority <= req_i.high_priority;
      cmd_q.volume        <= vol_sat;
      cmd_q.looping       <= req_i.looping;
      cmd_q.fin           <= req_i.finished_channel;
    end
  end

  assign link[0] = '0;

  for (genvar i = 0; i < TOTAL_CHANNELS; i++) begin : g_cell
    sva_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(i)),
      .bcast_i (bcast),
      .link_i  (link[i]),
      .link_o  (link[i+1])
    );
  end

  assign play_ok = exec && (cmd_q.command == CMD_PLAY) && cmd_q.known;
  assign stolen  = !link[TOTAL_CHANNELS].free_found;

  always_comb begin
    bcast.play_en   = play_ok;
    bcast.stop_en   = exec && (cmd_q.command == CMD_STOP);
    bcast.fin_en    = exec && (cmd_q.command == CMD_FINISH);
    bcast.all_busy  = stolen;
    bcast.steal_idx = cmd_q.high_priority ? high_ptr_q : low_ptr_q;
    bcast.tag       = cmd_q.tag;
    bcast.fin       = FIN_W'(cmd_q.fin);
  end

  always_comb begin
    high_ptr_d = high_ptr_q;
    low_ptr_d  = low_ptr_q;
    if (play_ok && stolen) begin
      if (cmd_q.high_priority) begin
        high_ptr_d = ((IDX_W+1)'(high_ptr_q) + 1'b1 >= (IDX_W+1)'(HIGH_CHANNELS))
                     ? '0 : high_ptr_q + 1'b1;
      end else begin
        low_ptr_d = ((IDX_W+1)'(low_ptr_q) + 1'b1 >= (IDX_W+1)'(TOTAL_CHANNELS))
                    ? IDX_W'(HIGH_CHANNELS) : low_ptr_q + 1'b1;
      end
    end
  end

  always_comb begin
    act_d  = ACT_NONE;
    ch_d   = '0;
    tag_d  = '0;
    vol_d  = '0;
    loop_d = 1'b0;
    case (cmd_q.command)
      CMD_PLAY: begin
        if (cmd_q.known) begin
          act_d  = stolen ? ACT_STOLEN : ACT_STARTED;
          ch_d   = stolen ? 4'(bcast.steal_idx) : 4'(link[TOTAL_CHANNELS].free_idx);
          tag_d  = 8'(cmd_q.tag);
          vol_d  = cmd_q.volume;
          loop_d = cmd_q.looping;
        end
      end
      CMD_STOP: begin
        if (link[TOTAL_CHANNELS].tag_found && link[TOTAL_CHANNELS].tag_playing) begin
          act_d = ACT_STOPPED;
          ch_d  = 4'(link[TOTAL_CHANNELS].tag_idx);
          tag_d = 8'(cmd_q.tag);
        end
      end
      default: begin
        act_d = ACT_NONE;
      end
    endcase
  end

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (exec) begin
      cmd_valid_d = 1'b0;
    end
    if (req_fire) begin
      cmd_valid_d = 1'b1;
    end
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (exec) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      high_ptr_q  <= '0;
      low_ptr_q   <= IDX_W'(HIGH_CHANNELS);
    end else begin
      cmd_valid_q <= cmd_valid_d;
      rsp_valid_q <= rsp_valid_d;
      high_ptr_q  <= high_ptr_d;
      low_ptr_q   <= low_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      act_q  <= act_d;
      ch_q   <= ch_d;
      tag_q  <= tag_d;
      vol_q  <= vol_d;
      loop_q <= loop_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.action      = act_q;
  assign rsp_o.channel     = ch_q;
  assign rsp_o.out_tag     = tag_q;
  assign rsp_o.out_volume  = vol_q;
  assign rsp_o.out_looping = loop_q;

`ifndef NO_ASSERTIONS
  a_exec_loads_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> rsp_valid_q)
    else $error("resolved command did not load the output register");

  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_q && !exec) |=> (cmd_valid_q && $stable(cmd_q)))
    else $error("pending command lost while output stalled");

  a_high_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IDX_W+1)'(high_ptr_q) < (IDX_W+1)'(HIGH_CHANNELS))
    else $error("high steal pointer left its region");

  a_low_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((IDX_W+1)'(low_ptr_q) >= (IDX_W+1)'(HIGH_CHANNELS)) &&
    ((IDX_W+1)'(low_ptr_q) < (IDX_W+1)'(TOTAL_CHANNELS)))
    else $error("low steal pointer left its region");
`endif

endmodule
